// File: src/ffba_pkg.sv
// ffba_pkg: shared constants and types for the first-fit block allocator.
// Used by first_fit_block_allocator_unit and ffba_checker; no dependencies.
package ffba_pkg;

    // Free list depth and the index/count widths it implies
    localparam int FREE_DEPTH = 16;
    localparam int IDX_W      = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FREE_DEPTH + 1);

    // Block header size in bytes
    localparam logic [31:0] HDR_BYTES = 32'd8;

    // Operation codes (carried in s_tuser)
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_REUSED   = 3'd0,
        STAT_NEW      = 3'd1,
        STAT_OOM      = 3'd2,
        STAT_FREED    = 3'd3,
        STAT_NULL     = 3'd4,
        STAT_OVERFLOW = 3'd5
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_MOV_RD,
        ST_MOV_WR,
        ST_MISS,
        ST_DONE
    } fsm_state_t;

endpackage

// File: src/first_fit_block_allocator_unit.sv
// first_fit_block_allocator_unit: first-fit allocator over a free list held in
// one synchronous RAM ({address, size} per entry). Depends on ffba_pkg.
//
// Channel | Direction | Signals                        | Contents
// --------+-----------+--------------------------------+----------------------------------
// s_      | in        | s_tvalid s_tready s_tdata/user | request: op, size, pointer, hdr
// m_      | out       | m_tvalid m_tready m_tdata      | result address and status
// cfg_    | in        | cfg_valid cfg_ready cfg_data   | heap_base write (reloads break)
//
// Steps: a free pushes onto the head; an allocate compares entries from
// the head downward and, on a hit, copies each entry above it down one
// place to close the gap; a miss bumps the break. The search reads one RAM
// entry a cycle through the single read port; removal copies one entry a cycle.
// One transaction is worked at a time; s_tready is high only when idle.
// A finished result is held in the output register while the next request
// is searched; the controller waits only if that register is still full.
// Reset (aresetn, synchronous, active low) empties the list, loads the break
// with 65536 and clears the output; the RAM is not cleared.
module first_fit_block_allocator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // Request transaction
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // [31:0] request_size, [63:32] user_pointer,
                                   // [95:64] header_size
    input  logic        s_tuser,   // [0] operation (0 allocate, 1 free)
    // Result transaction
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] result_address, [34:32] status,
                                   // [39:35] zero
    // Configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data   // heap_base
);

    localparam int IDX_W = ffba_pkg::IDX_W;
    localparam int CNT_W = ffba_pkg::CNT_W;

    // Free list RAM: [63:32] block address, [31:0] size word
    logic [63:0] list_ram [ffba_pkg::FREE_DEPTH];
    logic [63:0] mem_rdata_reg;
    logic [IDX_W-1:0] mem_raddr;
    logic [IDX_W-1:0] mem_waddr;
    logic [63:0] mem_wdata;
    logic mem_we;

    ffba_pkg::fsm_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [32:0] bp_reg, bp_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [31:0] req_reg, req_next;
    logic [31:0] res_addr_reg, res_addr_next;
    ffba_pkg::status_t res_stat_reg, res_stat_next;
    logic m_valid_reg, m_valid_next;
    logic [31:0] m_addr_reg, m_addr_next;
    ffba_pkg::status_t m_stat_reg, m_stat_next;

    // Input field views
    logic [31:0] in_req, in_ptr, in_hsize;
    assign in_req   = s_tdata[31:0];
    assign in_ptr   = s_tdata[63:32];
    assign in_hsize = s_tdata[95:64];

    // Miss path: round up, add header, check against the 4 GiB limit
    logic [32:0] rounded_raw, rounded;
    logic [33:0] total;
    logic [34:0] new_end;
    logic oom;
    assign rounded_raw = ({1'b0, req_reg} + 33'd7) & ~33'd7;
    assign rounded = (rounded_raw == 33'd0) ? 33'd8 : rounded_raw;
    assign total   = {1'b0, rounded} + {2'b0, ffba_pkg::HDR_BYTES};
    assign new_end = {2'b0, bp_reg} + {1'b0, total};
    assign oom     = (new_end > 35'h1_0000_0000);

    // Search compare on the entry read last cycle
    logic hit;
    assign hit = (mem_rdata_reg[31:0] >= req_reg);

    logic s_fire, m_fire, cfg_fire, out_free;
    assign s_tready  = (state_reg == ffba_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_fire    = s_tvalid && s_tready;
    assign m_fire    = m_valid_reg && m_tready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_free  = !m_valid_reg || m_tready;

    // RAM: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            list_ram[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= list_ram[mem_raddr];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ffba_pkg::ST_IDLE;
            count_reg   <= '0;
            bp_reg      <= 33'd65536;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            bp_reg      <= bp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        j_reg        <= j_next;
        req_reg      <= req_next;
        res_addr_reg <= res_addr_next;
        res_stat_reg <= res_stat_next;
        m_addr_reg   <= m_addr_next;
        m_stat_reg   <= m_stat_next;
    end

    // Next state and datapath control
    always_comb begin
        logic [CNT_W-1:0] head;
        logic [CNT_W:0]   j_plus2;
        head    = count_reg - CNT_W'(1);
        j_plus2 = {1'b0, j_reg} + (CNT_W+1)'(2);

        state_next    = state_reg;
        count_next    = count_reg;
        bp_next       = bp_reg;
        idx_next      = idx_reg;
        j_next        = j_reg;
        req_next      = req_reg;
        res_addr_next = res_addr_reg;
        res_stat_next = res_stat_reg;
        m_valid_next  = m_valid_reg;
        m_addr_next   = m_addr_reg;
        m_stat_next   = m_stat_reg;
        mem_raddr     = head[IDX_W-1:0];
        mem_we        = 1'b0;
        mem_waddr     = count_reg[IDX_W-1:0];
        mem_wdata     = {in_ptr - ffba_pkg::HDR_BYTES, in_hsize};

        // Output register drains independently
        if (m_fire) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ffba_pkg::ST_IDLE: begin
                // Read of the head is issued now for an allocate
                if (s_fire) begin
                    req_next      = in_req;
                    res_addr_next = '0;
                    state_next    = ffba_pkg::ST_DONE;
                    if (s_tuser == ffba_pkg::OP_ALLOC) begin
                        idx_next   = head[IDX_W-1:0];
                        state_next = (count_reg == '0) ? ffba_pkg::ST_MISS
                                                       : ffba_pkg::ST_CMP;
                    end else if (in_ptr == 32'd0) begin
                        res_stat_next = ffba_pkg::STAT_NULL;
                    end else if (count_reg >= CNT_W'(ffba_pkg::FREE_DEPTH)) begin
                        res_stat_next = ffba_pkg::STAT_OVERFLOW;
                    end else begin
                        // Push onto the head
                        mem_we        = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                        res_stat_next = ffba_pkg::STAT_FREED;
                    end
                end
            end
            ffba_pkg::ST_CMP: begin
                // Compare entry idx, read idx-1 for the following cycle
                mem_raddr = idx_reg - IDX_W'(1);
                if (hit) begin
                    res_addr_next = mem_rdata_reg[63:32] + ffba_pkg::HDR_BYTES;
                    res_stat_next = ffba_pkg::STAT_REUSED;
                    j_next        = CNT_W'(idx_reg);
                    if ((CNT_W'(idx_reg) + CNT_W'(1)) < count_reg) begin
                        state_next = ffba_pkg::ST_MOV_RD;
                    end else begin
                        count_next = head;
                        state_next = ffba_pkg::ST_DONE;
                    end
                end else if (idx_reg == '0) begin
                    state_next = ffba_pkg::ST_MISS;
                end else begin
                    idx_next = idx_reg - IDX_W'(1);
                end
            end
            ffba_pkg::ST_MOV_RD: begin
                mem_raddr  = IDX_W'(j_reg + CNT_W'(1));
                state_next = ffba_pkg::ST_MOV_WR;
            end
            ffba_pkg::ST_MOV_WR: begin
                // Shift entry j+1 down to j, read j+2 behind it
                mem_we    = 1'b1;
                mem_waddr = j_reg[IDX_W-1:0];
                mem_wdata = mem_rdata_reg;
                mem_raddr = j_plus2[IDX_W-1:0];
                j_next    = j_reg + CNT_W'(1);
                if (j_plus2 >= {1'b0, count_reg}) begin
                    count_next = head;
                    state_next = ffba_pkg::ST_DONE;
                end
            end
            ffba_pkg::ST_MISS: begin
                // Bump the break unless it would pass the limit
                if (oom) begin
                    res_addr_next = '0;
                    res_stat_next = ffba_pkg::STAT_OOM;
                end else begin
                    res_addr_next = bp_reg[31:0] + ffba_pkg::HDR_BYTES;
                    res_stat_next = ffba_pkg::STAT_NEW;
                    bp_next       = new_end[32:0];
                end
                state_next = ffba_pkg::ST_DONE;
            end
            ffba_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_addr_next  = res_addr_reg;
                    m_stat_next  = res_stat_reg;
                    state_next   = ffba_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ffba_pkg::ST_IDLE;
            end
        endcase

        // Configuration reloads the break pointer
        if (cfg_fire) begin
            bp_next = {1'b0, cfg_data};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_stat_reg, m_addr_reg};

endmodule

// File: src/ffba_checker.sv
// ffba_checker: port-level assertions for first_fit_block_allocator_unit,
// bound to the top level below. Depends on ffba_pkg.
module ffba_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    logic [2:0] stat;
    assign stat = m_tdata[34:32];

    // No result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // One request in flight: acceptance closes the input side next cycle
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request accepted while busy");

    // Only allocation successes carry an address
    a_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && stat != ffba_pkg::STAT_REUSED && stat != ffba_pkg::STAT_NEW
        |-> m_tdata[31:0] == 32'd0)
        else $error("nonzero address on failure or free");

    // Status code in range, padding clear
    a_stat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> stat <= 3'd5 && m_tdata[39:35] == 5'd0)
        else $error("bad status or padding");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
